>>> rtl/fru_type_length_field_decoder_assert.svh
// Assertion macros shared by the decoder modules.
`ifndef FRU_TYPE_LENGTH_FIELD_DECODER_ASSERT_SVH
`define FRU_TYPE_LENGTH_FIELD_DECODER_ASSERT_SVH

// Condition must hold on every clock edge out of reset.
`define FTLD_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ftld invariant violated");

// Consequent must hold whenever the antecedent does.
`define FTLD_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ftld implication violated");

`endif

>>> rtl/ftld_pkg.sv
// Types, constants and character tables for the FRU type/length field decoder.
package ftld_pkg;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [7:0] END_OF_FIELDS = 8'hC1;
	localparam logic [7:0] SIX_BIT_BIAS  = 8'h20;

	localparam logic [1:0] TYPE_BINARY = 2'd0;
	localparam logic [1:0] TYPE_BCD    = 2'd1;
	localparam logic [1:0] TYPE_SIXBIT = 2'd2;
	localparam logic [1:0] TYPE_ASCII8 = 2'd3;

	typedef enum logic [2:0] {
		JOB_SINGLE = 3'b001,
		JOB_HEX    = 3'b010,
		JOB_SIX    = 3'b100
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [23:0] word;
		logic [1:0]  field_type;
		logic        last;
		logic        empty;
		logic        end_mark;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10)
			c = 8'h30 + {4'd0, nib};
		else
			c = 8'h57 + {4'd0, nib};
		return c;
	endfunction

	function automatic logic [7:0] bcd_char(input logic [3:0] nib);
		logic [7:0] c;
		case (nib)
			4'd10:   c = 8'h20;
			4'd11:   c = 8'h2D;
			4'd12:   c = 8'h2E;
			4'd13:   c = 8'h3A;
			4'd14:   c = 8'h2C;
			4'd15:   c = 8'h5F;
			default: c = 8'h30 + {4'd0, nib};
		endcase
		return c;
	endfunction

endpackage

>>> rtl/ftld_queue.sv
// Request queue between the classifying front and the character back end.
`include "fru_type_length_field_decoder_assert.svh"

module ftld_queue
	import ftld_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  job_req_t push,
	output logic     full,
	output job_req_t head,
	input  logic     pop
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign do_push = push.valid && !full;
	assign do_pop  = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.job   = mem_q[rd_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(DEPTH - 1))
			n = '0;
		else
			n = p + PW'(1);
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push.job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= bump(wr_q);
			if (do_pop)
				rd_q <= bump(rd_q);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	`FTLD_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH))
	`FTLD_ASSERT_IMPLIES(a_no_push_full, push.valid, !full)
	`FTLD_ASSERT_IMPLIES(a_no_pop_empty, pop, count_q != '0)

endmodule

>>> rtl/ftld_front.sv
// Front end: accepts stream bytes, tracks field state and issues character requests.
module ftld_front
	import ftld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       q_full,
	output job_req_t   push
);

	logic        in_payload_q;
	logic [1:0]  type_q;
	logic [5:0]  left_q;
	logic [1:0]  cnt_q;
	logic [15:0] grp_q;

	logic       accept;
	logic [5:0] left_n;
	logic       fin;
	logic       has_job;
	job_t       job;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign left_n   = left_q - 6'd1;
	assign fin      = (left_n == 6'd0);

	always_comb begin
		has_job       = 1'b0;
		job.kind      = JOB_SINGLE;
		job.word      = '0;
		job.field_type = type_q;
		job.last      = fin;
		job.empty     = 1'b0;
		job.end_mark  = 1'b0;
		if (!in_payload_q) begin
			job.field_type = data_byte[7:6];
			job.last       = 1'b1;
			if (data_byte == END_OF_FIELDS) begin
				has_job        = 1'b1;
				job.field_type = TYPE_ASCII8;
				job.end_mark   = 1'b1;
			end else if (data_byte[5:0] == 6'd0) begin
				has_job   = 1'b1;
				job.empty = 1'b1;
			end
		end else begin
			case (type_q)
				TYPE_BINARY: begin
					has_job  = 1'b1;
					job.kind = JOB_HEX;
					job.word = {16'd0, data_byte};
				end
				TYPE_BCD: begin
					has_job  = 1'b1;
					job.word = {16'd0, bcd_char(data_byte[3:0])};
				end
				TYPE_SIXBIT: begin
					has_job  = (cnt_q == 2'd2) || fin;
					job.kind = JOB_SIX;
					case (cnt_q)
						2'd0:    job.word = {16'd0, data_byte};
						2'd1:    job.word = {8'd0, data_byte, grp_q[7:0]};
						default: job.word = {data_byte, grp_q};
					endcase
				end
				default: begin
					has_job  = 1'b1;
					job.word = {16'd0, data_byte};
				end
			endcase
		end
	end

	assign push.valid = accept && has_job;
	assign push.job   = job;

	always_ff @(posedge clk) begin
		if (accept && in_payload_q) begin
			if (cnt_q == 2'd0)
				grp_q[7:0] <= data_byte;
			else
				grp_q[15:8] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			type_q       <= TYPE_BINARY;
			left_q       <= '0;
			cnt_q        <= '0;
		end else if (accept) begin
			if (!in_payload_q) begin
				if (data_byte != END_OF_FIELDS && data_byte[5:0] != 6'd0) begin
					in_payload_q <= 1'b1;
					type_q       <= data_byte[7:6];
					left_q       <= data_byte[5:0];
					cnt_q        <= '0;
				end
			end else begin
				left_q <= left_n;
				if (fin) begin
					in_payload_q <= 1'b0;
					cnt_q        <= '0;
				end else if (type_q == TYPE_SIXBIT) begin
					if (cnt_q == 2'd2)
						cnt_q <= '0;
					else
						cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

endmodule

>>> rtl/ftld_back.sv
// Back end: expands queued requests into characters behind an output register.
`include "fru_type_length_field_decoder_assert.svh"

module ftld_back
	import ftld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  job_req_t   head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_code,
	output logic [1:0] field_type,
	output logic       last_of_field,
	output logic       empty_field,
	output logic       end_marker
);

	logic [1:0] k_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic [1:0] type_q;
	logic       last_q;
	logic       empty_q;
	logic       end_q;

	logic [1:0] k_last;
	logic       load;
	logic       final_char;
	logic [7:0] ch;
	logic [5:0] six;

	always_comb begin
		case (head.job.kind)
			JOB_HEX: k_last = 2'd1;
			JOB_SIX: k_last = 2'd3;
			default: k_last = 2'd0;
		endcase
	end

	always_comb begin
		case (k_q)
			2'd0:    six = head.job.word[5:0];
			2'd1:    six = head.job.word[11:6];
			2'd2:    six = head.job.word[17:12];
			default: six = head.job.word[23:18];
		endcase
	end

	always_comb begin
		case (head.job.kind)
			JOB_HEX: ch = (k_q == 2'd0) ? hex_char(head.job.word[7:4])
			                            : hex_char(head.job.word[3:0]);
			JOB_SIX: ch = {2'b00, six} + SIX_BIT_BIAS;
			default: ch = head.job.word[7:0];
		endcase
	end

	assign load       = head.valid && (!valid_q || !out_stall);
	assign final_char = (k_q == k_last);
	assign pop        = load && final_char;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q  <= ch;
			type_q  <= head.job.field_type;
			last_q  <= head.job.last && final_char;
			empty_q <= head.job.empty;
			end_q   <= head.job.end_mark;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (!valid_q || !out_stall)
				valid_q <= head.valid;
			if (load) begin
				if (final_char)
					k_q <= '0;
				else
					k_q <= k_q + 2'd1;
			end
		end
	end

	assign out_valid     = valid_q;
	assign char_code     = char_q;
	assign field_type    = type_q;
	assign last_of_field = last_q;
	assign empty_field   = empty_q;
	assign end_marker    = end_q;

	`FTLD_ASSERT_IMPLIES(a_mid_request_held, k_q != 2'd0, head.valid)
	`FTLD_ASSERT_IMPLIES(a_empty_is_last, valid_q && empty_q, last_q && char_q == 8'd0)
	`FTLD_ASSERT_IMPLIES(a_end_shape, valid_q && end_q,
		last_q && !empty_q && type_q == TYPE_ASCII8 && char_q == 8'd0)

endmodule

>>> rtl/fru_type_length_field_decoder.sv
// Top level of the FRU type/length field decoder.
//
// Input channel: in_valid / in_stall carry one stream byte (data_byte) per
// request, header or payload. Output channel: out_valid / out_stall carry one
// character per request with field_type, last_of_field, empty_field and
// end_marker. A byte is taken whenever the request queue has room; the front
// end turns it into zero or one queued request, the back end expands each
// request into one to four characters, one per cycle while out_stall is low.
// A taken byte's request is written into the queue; the back end then loads
// its characters into the output register that drives the output channel.
// Throughput: one input byte per cycle while the queue has room, and one
// character per cycle while out_stall is low; binary fields (two characters
// per byte) and six-bit groups (four per three bytes) are paced by the
// single-character output. When the receiver stalls, the output register
// holds, the queue fills and in_stall rises once QUEUE_DEPTH requests wait.
// Reset clears the field state, the queue and the output valid; the decoder
// then expects a header byte.
module fru_type_length_field_decoder
	import ftld_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_code,
	output logic [1:0] field_type,
	output logic       last_of_field,
	output logic       empty_field,
	output logic       end_marker
);

	job_req_t push;
	job_req_t head;
	logic     q_full;
	logic     pop;

	ftld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push)
	);

	ftld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	ftld_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.char_code     (char_code),
		.field_type    (field_type),
		.last_of_field (last_of_field),
		.empty_field   (empty_field),
		.end_marker    (end_marker)
	);

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the FRU type/length field decoder: directed, random and backpressure tests.
module tb_top
	import ftld_pkg::*;
();

	typedef struct packed {
		logic [7:0] code;
		logic [1:0] ftype;
		logic       last;
		logic       empty;
		logic       endm;
	} char_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] char_code;
	logic [1:0] field_type;
	logic       last_of_field;
	logic       empty_field;
	logic       end_marker;

	char_t pending_chars[$];

	// decoder state as predicted
	bit         pr_in_payload;
	logic [1:0] pr_type;
	logic [5:0] pr_left;
	logic [15:0] pr_group;
	logic [1:0] pr_count;

	string hex_glyphs = "0123456789abcdef";
	string bcd_glyphs = "0123456789 -.:,_";

	bit idle_on;
	bit hold_request;
	int mismatches;
	int bytes_sent;
	int chars_checked;
	int headers_seen;
	int ends_seen;
	int input_stall_cycles;

	fru_type_length_field_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.char_code    (char_code),
		.field_type   (field_type),
		.last_of_field(last_of_field),
		.empty_field  (empty_field),
		.end_marker   (end_marker)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void queue_char(logic [7:0] code, logic [1:0] ftype, logic last,
			logic empty, logic endm);
		char_t c;
		c.code  = code;
		c.ftype = ftype;
		c.last  = last;
		c.empty = empty;
		c.endm  = endm;
		pending_chars.push_back(c);
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		logic        fin;
		logic [23:0] w;
		if (!pr_in_payload) begin
			headers_seen++;
			if (b == END_OF_FIELDS) begin
				ends_seen++;
				queue_char(8'h00, TYPE_ASCII8, 1'b1, 1'b0, 1'b1);
			end else if (b[5:0] == 6'd0) begin
				queue_char(8'h00, b[7:6], 1'b1, 1'b1, 1'b0);
			end else begin
				pr_in_payload = 1'b1;
				pr_type  = b[7:6];
				pr_left  = b[5:0];
				pr_group = '0;
				pr_count = '0;
			end
			return;
		end
		pr_left = pr_left - 6'd1;
		fin = (pr_left == 6'd0);
		case (pr_type)
			TYPE_BINARY: begin
				queue_char(hex_glyphs[b[7:4]], TYPE_BINARY, 1'b0, 1'b0, 1'b0);
				queue_char(hex_glyphs[b[3:0]], TYPE_BINARY, fin, 1'b0, 1'b0);
			end
			TYPE_BCD: queue_char(bcd_glyphs[b[3:0]], TYPE_BCD, fin, 1'b0, 1'b0);
			TYPE_ASCII8: queue_char(b, TYPE_ASCII8, fin, 1'b0, 1'b0);
			default: begin
				if (pr_count == 2'd0)
					pr_group = {8'h00, b};
				else if (pr_count == 2'd1)
					pr_group[15:8] = b;
				if (pr_count == 2'd2 || fin) begin
					if (pr_count == 2'd0)
						w = {16'h0000, b};
					else if (pr_count == 2'd1)
						w = {8'h00, pr_group};
					else
						w = {b, pr_group};
					for (int k = 0; k < 4; k++)
						queue_char({2'b00, w[6*k +: 6]} + SIX_BIT_BIAS, TYPE_SIXBIT,
							fin && k == 3, 1'b0, 1'b0);
					pr_group = '0;
					pr_count = '0;
				end else begin
					pr_count = pr_count + 2'd1;
				end
			end
		endcase
		if (fin) begin
			pr_in_payload = 1'b0;
			pr_group = '0;
			pr_count = '0;
		end
	endfunction

	function automatic int spread_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int pick_gap();
		if (!idle_on || $urandom_range(0, 9) < 6)
			return 0;
		return spread_len();
	endfunction

	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		decode_byte(b);
		bytes_sent++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_chars.size() != 0);
	endtask

	// header plus payload; cut drops trailing payload bytes to break the field
	task automatic send_field(input logic [1:0] ty, input int len, input int cut);
		logic [7:0] hdr;
		hdr = {ty, len[5:0]};
		push_byte(hdr);
		if (hdr == END_OF_FIELDS)
			return;
		for (int i = 0; i < len - cut; i++)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic report_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v,
				act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		char_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual 0x%0h",
					$time, char_code);
				mismatches++;
			end else begin
				e = pending_chars.pop_front();
				report_field("char_code", int'(e.code), int'(char_code));
				report_field("field_type", int'(e.ftype), int'(field_type));
				report_field("last_of_field", int'(e.last), int'(last_of_field));
				report_field("empty_field", int'(e.empty), int'(empty_field));
				report_field("end_marker", int'(e.endm), int'(end_marker));
				chars_checked++;
			end
		end
	end

	initial begin : receiver
		int run;
		int hold_left;
		bit st;
		run = 0;
		hold_left = 0;
		st = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (run == 0) begin
					st = idle_on && $urandom_range(0, 3) == 0;
					run = st ? spread_len() : $urandom_range(1, 8);
				end
				run--;
				out_stall <= st;
			end
		end
	end

	task automatic test_directed_cases();
		push_byte(END_OF_FIELDS);
		push_byte({TYPE_BINARY, 6'd0});
		push_byte({TYPE_BCD, 6'd0});
		push_byte({TYPE_SIXBIT, 6'd0});
		push_byte({TYPE_ASCII8, 6'd0});
		push_byte({TYPE_BINARY, 6'd2});
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte({TYPE_BCD, 6'd3});
		push_byte(8'h0A);
		push_byte(8'hFF);
		push_byte(8'h5C);
		// end-of-fields value inside a payload is plain data
		push_byte({TYPE_ASCII8, 6'd2});
		push_byte(8'h00);
		push_byte(END_OF_FIELDS);
		// six-bit: one and two byte tails padded, then a full group
		push_byte({TYPE_SIXBIT, 6'd1});
		push_byte(8'hA5);
		push_byte({TYPE_SIXBIT, 6'd2});
		push_byte(8'h3C);
		push_byte(8'hC3);
		push_byte({TYPE_SIXBIT, 6'd3});
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'hFF);
		wait_for_results();
	endtask

	task automatic test_random_fields(input int n_items);
		int start;
		int k;
		start = bytes_sent;
		while (bytes_sent - start < n_items) begin
			if ($urandom_range(0, 7) == 0)
				idle_on = !idle_on;
			k = $urandom_range(0, 99);
			if (k < 8)
				push_byte(8'($urandom_range(0, 255)));
			else if (k < 12)
				push_byte(END_OF_FIELDS);
			else if (k < 18)
				send_field(2'($urandom_range(0, 3)), 0, 0);
			else if (k < 21)
				send_field(2'($urandom_range(0, 3)), $urandom_range(40, 63), 0);
			else if (k < 28)
				send_field(2'($urandom_range(0, 3)), $urandom_range(2, 8), 1);
			else
				send_field(2'($urandom_range(0, 3)), $urandom_range(1, 8), 0);
		end
		wait_for_results();
	endtask

	task automatic test_output_backpressure();
		idle_on = 1'b0;
		hold_request = 1'b1;
		send_field(TYPE_BINARY, 16, 0);
		wait_for_results();
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		idle_on   = 1'b1;
		hold_request = 1'b0;
		mismatches = 0;
		bytes_sent = 0;
		chars_checked = 0;
		headers_seen = 0;
		ends_seen = 0;
		input_stall_cycles = 0;
		pr_in_payload = 1'b0;
		pr_type  = '0;
		pr_left  = '0;
		pr_group = '0;
		pr_count = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_output_backpressure();
		idle_on = 1'b1;
		test_random_fields(170);

		wait_for_results();
		repeat (20) @(posedge clk);
		$display("Covered %0d stream bytes, %0d headers of which %0d end markers, %0d characters",
			bytes_sent, headers_seen, ends_seen, chars_checked);
		$display("Input held off for %0d cycles under output backpressure",
			input_stall_cycles);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out waiting for the decoder");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/ftld_pkg.sv
rtl/ftld_queue.sv
rtl/ftld_front.sv
rtl/ftld_back.sv
rtl/fru_type_length_field_decoder.sv
bench/tb_top.sv
